// ===== hdl/tfw_pkg.sv =====
// Shared types, codes and helpers of the text and pixel framebuffer writer.
package tfw_pkg;

  localparam int unsigned GLYPH_WIDTH = 8;
  localparam int unsigned FONT_AW     = 12;
  localparam int unsigned ADDR_W      = 28;
  localparam int unsigned DATA_W      = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 16;

  localparam logic [1:0] KIND_FONT  = 2'd0;
  localparam logic [1:0] KIND_CHAR  = 2'd1;
  localparam logic [1:0] KIND_PIXEL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLUMNS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_DEPTH  = 2'd3;

  localparam logic        RST_DISPLAY_MODE = 1'b0;
  localparam logic [7:0]  RST_TEXT_COLUMNS = 8'd80;
  localparam logic [15:0] RST_LINE_PITCH   = 16'd4096;
  localparam logic [1:0]  RST_PIXEL_DEPTH  = 2'd3;

  localparam logic       MODE_TEXT    = 1'b0;
  localparam logic       MODE_GRAPHIC = 1'b1;

  localparam logic [1:0] DEPTH_8  = 2'd0;
  localparam logic [1:0] DEPTH_16 = 2'd1;
  localparam logic [1:0] DEPTH_24 = 2'd2;
  localparam logic [1:0] DEPTH_32 = 2'd3;

  localparam logic [7:0] BYTE_LIT   = 8'hFF;
  localparam logic [7:0] BYTE_UNLIT = 8'h00;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_PAIR,
    ST_TEXT,
    ST_PIXEL
  } tfw_state_e;

  typedef struct packed {
    logic        display_mode;
    logic [7:0]  text_columns;
    logic [15:0] line_pitch;
    logic [1:0]  pixel_depth;
  } tfw_cfg_t;

  typedef struct packed {
    logic [11:0] a;
    logic [15:0] b;
    logic [15:0] c;
  } tfw_mac_req_t;

  typedef struct packed {
    logic               we;
    logic [FONT_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [FONT_AW-1:0] raddr;
  } tfw_ram_req_t;

  // x times bytes per pixel
  function automatic logic [13:0] tfw_xscale(input logic [11:0] x, input logic [1:0] depth);
    logic [13:0] xe;
    logic [13:0] r;
    xe = {2'b00, x};
    unique case (depth)
      DEPTH_8:  r = xe;
      DEPTH_16: r = xe << 1;
      DEPTH_24: r = xe + (xe << 1);
      default:  r = xe << 2;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/tfw_if.sv =====
// Request and write channel interfaces of the framebuffer writer.
interface tfw_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  char_code;
  logic [7:0]  text_row;
  logic [7:0]  text_col;
  logic [7:0]  attribute;
  logic [31:0] color;
  logic [11:0] pixel_x;
  logic [11:0] pixel_y;
  logic [11:0] font_index;
  logic [7:0]  font_byte;

  modport source (
    output valid, kind, char_code, text_row, text_col, attribute, color,
           pixel_x, pixel_y, font_index, font_byte,
    input  ready
  );
  modport sink (
    input  valid, kind, char_code, text_row, text_col, attribute, color,
           pixel_x, pixel_y, font_index, font_byte,
    output ready
  );
endinterface

interface tfw_out_if;
  logic        valid;
  logic        ready;
  logic [27:0] write_address;
  logic [63:0] write_data;
  logic [3:0]  byte_count;
  logic        last_write;

  modport source (
    output valid, write_address, write_data, byte_count, last_write,
    input  ready
  );
  modport sink (
    input  valid, write_address, write_data, byte_count, last_write,
    output ready
  );
endinterface

// ===== hdl/tfw_glyph_ram.sv =====
// Glyph store: 4096 x 8 bit font memory with registered read.
module tfw_glyph_ram
  import tfw_pkg::*;
(
  input  logic         clk_i,
  input  tfw_ram_req_t req_i,
  output logic [7:0]   rdata_o
);

  logic [7:0] mem [2**FONT_AW];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/tfw_mac.sv =====
// Shared multiply-add unit: a * b + c, wrapped to the address width.
module tfw_mac
  import tfw_pkg::*;
(
  input  tfw_mac_req_t       req_i,
  output logic [ADDR_W-1:0]  sum_o
);

  logic [ADDR_W-1:0] prod;

  assign prod  = ADDR_W'({16'b0, req_i.a} * {12'b0, req_i.b});
  assign sum_o = prod + ADDR_W'(req_i.c);

endmodule

// ===== hdl/tfw_seq.sv =====
// Sequencer: takes requests, walks glyph pairs and holds the output beat.
module tfw_seq
  import tfw_pkg::*;
#(
  parameter int unsigned GLYPH_HEIGHT = 16,
  parameter int unsigned GLYPH_COUNT  = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tfw_cfg_t          cfg_i,
  tfw_in_if.sink            req,
  tfw_out_if.source         wr,
  output tfw_mac_req_t      mac_o,
  input  logic [ADDR_W-1:0] mac_sum_i,
  output tfw_ram_req_t      ram_o,
  input  logic [7:0]        line_i
);

  localparam int unsigned DY_W = $clog2(GLYPH_HEIGHT);

  tfw_state_e state_q, state_d;

  logic [7:0]   code_q, row_q, col_q, attr_q;
  logic [31:0]  color_q;
  logic [11:0]  px_q, py_q;
  logic [11:0]  gy_q, gy_d;
  logic [FONT_AW-1:0] fptr_q, fptr_d;
  logic [DY_W-1:0] dy_q, dy_d;
  logic [1:0]   pair_q, pair_d;

  logic         accept;
  logic         load_ok;
  logic         emit;
  logic         last_line;
  logic [7:0]   code_w;
  logic [2:0]   bpp;
  logic         lit0, lit1;
  logic [7:0]   byte0, byte1;
  logic [63:0]  pair_data;
  logic [63:0]  pix_data;
  logic [63:0]  beat_data;
  logic [3:0]   beat_count;
  logic         beat_last;

  logic         out_valid_q;
  logic [ADDR_W-1:0] out_addr_q;
  logic [DATA_W-1:0] out_data_q;
  logic [3:0]   out_count_q;
  logic         out_last_q;

  function automatic int unsigned row_in_h(input logic [7:0] row);
    return int'(row) * GLYPH_HEIGHT;
  endfunction

  assign accept    = req.valid && req.ready;
  assign load_ok   = !out_valid_q || wr.ready;
  assign last_line = (dy_q == DY_W'(GLYPH_HEIGHT - 1));
  assign bpp       = {1'b0, cfg_i.pixel_depth} + 3'd1;
  assign code_w    = ({1'b0, req.char_code} >= 9'(GLYPH_COUNT))
                   ? req.char_code - 8'(GLYPH_COUNT) : req.char_code;

  assign lit0  = line_i[{~pair_q, 1'b1}];
  assign lit1  = line_i[{~pair_q, 1'b0}];
  assign byte0 = lit0 ? BYTE_LIT : BYTE_UNLIT;
  assign byte1 = lit1 ? BYTE_LIT : BYTE_UNLIT;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < {1'b0, bpp}) begin
        pair_data[8*i +: 8] = byte0;
      end else if (4'(i) < {bpp, 1'b0}) begin
        pair_data[8*i +: 8] = byte1;
      end else begin
        pair_data[8*i +: 8] = 8'h00;
      end
    end
  end

  always_comb begin
    unique case (cfg_i.pixel_depth)
      DEPTH_8:  pix_data = {56'b0, BYTE_LIT};
      DEPTH_16: pix_data = {48'b0, color_q[23:19], color_q[15:10], color_q[7:3]};
      DEPTH_24: pix_data = {40'b0, color_q[23:0]};
      default:  pix_data = {32'b0, color_q};
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req.kind == KIND_CHAR) begin
            state_d = (cfg_i.display_mode == MODE_GRAPHIC) ? ST_FETCH : ST_TEXT;
          end else if (req.kind == KIND_PIXEL) begin
            state_d = ST_PIXEL;
          end
        end
      end
      ST_FETCH: state_d = ST_PAIR;
      ST_PAIR: begin
        if (load_ok && pair_q == 2'd3 && last_line) begin
          state_d = ST_IDLE;
        end
      end
      ST_TEXT, ST_PIXEL: begin
        if (load_ok) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready   = (state_q == ST_IDLE);
    emit        = 1'b0;
    ram_o.we    = accept && (req.kind == KIND_FONT);
    ram_o.waddr = req.font_index;
    ram_o.wdata = req.font_byte;
    ram_o.re    = 1'b0;
    ram_o.raddr = fptr_q;
    mac_o.a     = gy_q;
    mac_o.b     = cfg_i.line_pitch;
    mac_o.c     = {2'b0, tfw_xscale({1'b0, col_q, pair_q, 1'b0}, cfg_i.pixel_depth)};
    beat_data   = pair_data;
    beat_count  = {bpp, 1'b0};
    beat_last   = (pair_q == 2'd3) && last_line;
    gy_d        = gy_q;
    fptr_d      = fptr_q;
    dy_d        = dy_q;
    pair_d      = pair_q;
    unique case (state_q)
      ST_IDLE: begin
        gy_d   = 12'(row_in_h(req.text_row));
        fptr_d = FONT_AW'(code_w * GLYPH_HEIGHT);
        dy_d   = '0;
        pair_d = '0;
      end
      ST_FETCH: begin
        ram_o.re = 1'b1;
        fptr_d   = fptr_q + FONT_AW'(1);
      end
      ST_PAIR: begin
        if (load_ok) begin
          emit   = 1'b1;
          pair_d = pair_q + 2'd1;
          if (pair_q == 2'd3) begin
            ram_o.re = 1'b1;
            fptr_d   = fptr_q + FONT_AW'(1);
            dy_d     = dy_q + DY_W'(1);
            gy_d     = gy_q + 12'd1;
          end
        end
      end
      ST_TEXT: begin
        emit       = load_ok;
        mac_o.a    = {4'b0, row_q};
        mac_o.b    = {7'b0, cfg_i.text_columns, 1'b0};
        mac_o.c    = {7'b0, col_q, 1'b0};
        beat_data  = {48'b0, attr_q, code_q};
        beat_count = 4'd2;
        beat_last  = 1'b1;
      end
      ST_PIXEL: begin
        emit       = load_ok;
        mac_o.a    = py_q;
        mac_o.c    = {2'b0, tfw_xscale(px_q, cfg_i.pixel_depth)};
        beat_data  = pix_data;
        beat_count = {1'b0, bpp};
        beat_last  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      dy_q        <= '0;
      pair_q      <= '0;
    end else begin
      state_q <= state_d;
      dy_q    <= dy_d;
      pair_q  <= pair_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (wr.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gy_q   <= gy_d;
    fptr_q <= fptr_d;
    if (accept) begin
      code_q  <= req.char_code;
      row_q   <= req.text_row;
      col_q   <= req.text_col;
      attr_q  <= req.attribute;
      color_q <= req.color;
      px_q    <= req.pixel_x;
      py_q    <= req.pixel_y;
    end
    if (emit) begin
      out_addr_q  <= mac_sum_i;
      out_data_q  <= beat_data;
      out_count_q <= beat_count;
      out_last_q  <= beat_last;
    end
  end

  assign wr.valid         = out_valid_q;
  assign wr.write_address = out_addr_q;
  assign wr.write_data    = out_data_q;
  assign wr.byte_count    = out_count_q;
  assign wr.last_write    = out_last_q;

endmodule

// ===== hdl/text_and_pixel_framebuffer_writer.sv =====
// Top level of the text and pixel framebuffer writer.
// Font load: no write beat. Text cell or pixel: the request is registered, then the text or
// pixel state loads the beat into the output register when it is free. Graphics character:
// accept, a glyph fetch state, then one two-pixel beat per cycle while the output is not
// stalled, for GLYPH_HEIGHT*4 beats; an output stall holds the sequencer. Reset returns the
// sequencer to idle and loads register defaults; the glyph store is not cleared.
module text_and_pixel_framebuffer_writer
  import tfw_pkg::*;
#(
  parameter int unsigned GLYPH_HEIGHT = 16,
  parameter int unsigned GLYPH_COUNT  = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  tfw_in_if.sink                req_if,
  tfw_out_if.source             wr_if
);

  tfw_cfg_t          cfg_q;
  tfw_mac_req_t      mac_req;
  logic [ADDR_W-1:0] mac_sum;
  tfw_ram_req_t      ram_req;
  logic [7:0]        glyph_line;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.display_mode <= RST_DISPLAY_MODE;
      cfg_q.text_columns <= RST_TEXT_COLUMNS;
      cfg_q.line_pitch   <= RST_LINE_PITCH;
      cfg_q.pixel_depth  <= RST_PIXEL_DEPTH;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DISPLAY_MODE: cfg_q.display_mode <= cfg_data_i[0];
        REG_TEXT_COLUMNS: cfg_q.text_columns <= cfg_data_i[7:0];
        REG_LINE_PITCH:   cfg_q.line_pitch   <= cfg_data_i;
        REG_PIXEL_DEPTH:  cfg_q.pixel_depth  <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  tfw_seq #(
    .GLYPH_HEIGHT (GLYPH_HEIGHT),
    .GLYPH_COUNT  (GLYPH_COUNT)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .req       (req_if),
    .wr        (wr_if),
    .mac_o     (mac_req),
    .mac_sum_i (mac_sum),
    .ram_o     (ram_req),
    .line_i    (glyph_line)
  );

  tfw_mac u_mac (
    .req_i (mac_req),
    .sum_o (mac_sum)
  );

  tfw_glyph_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (glyph_line)
  );

endmodule
